// ===== rtl/wmm_pkg.sv =====
`timescale 1ns / 1ps

package wmm_pkg;

  localparam int unsigned TsW       = 64;
  localparam int unsigned ValW      = 32;
  localparam int unsigned CntW      = 32;
  localparam int unsigned IntervalW = 40;
  localparam int unsigned MaxRes    = 3;

  typedef enum logic [1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_REQUEST = 2'd1,
    MODE_RESET   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SNAPSHOT = 2'd0,
    KIND_WINDOW   = 2'd1,
    KIND_ACK      = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic                    ready_res;
    logic [TsW-1:0]          start_ns;
    logic [TsW-1:0]          end_ns;
    logic signed [ValW-1:0]  raw_min;
    logic signed [ValW-1:0]  raw_max;
    logic signed [ValW-1:0]  gat_min;
    logic signed [ValW-1:0]  gat_max;
    logic [CntW-1:0]         samples;
    logic [TsW-1:0]          rollover_id;
    logic                    last;
  } rec_t;

endpackage

// ===== rtl/windowed_min_max_tracker.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// --------  ---------  --------------------------  --------------------------------------
// in        input      in_valid_i / in_ready_o     mode, timestamp_ns, raw/gated cross
// out       output     out_valid_o / out_ready_i   one result word per handshake
// cfg       input      cfg_we_i, no wait           cfg_wdata_i = window_interval_ns
//
// An accepted word waits in the input register until the result queue is empty or its last
// word leaves; then all of its work is done in a single pass and its up to three result words
// are loaded into a three-entry result queue.
// The queue drains one word per cycle while out_ready_i is high, so the rate at which samples
// are taken is set by the number of results each causes on the single output channel.
// A new input word is taken while earlier results still wait, and the next item is processed
// in the same cycle as the last result of the previous one leaves.
// Reset clears the window state, the counters, the interval register and both valid flags.

module windowed_min_max_tracker
  import wmm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_we_i,
  input  logic [IntervalW-1:0]   cfg_wdata_i,

  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             mode_i,
  input  logic [TsW-1:0]         timestamp_ns_i,
  input  logic signed [ValW-1:0] raw_cross_i,
  input  logic signed [ValW-1:0] gated_cross_i,

  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             kind_o,
  output logic                   ready_res_o,
  output logic [TsW-1:0]         start_ns_o,
  output logic [TsW-1:0]         end_ns_o,
  output logic signed [ValW-1:0] raw_minimum_o,
  output logic signed [ValW-1:0] raw_maximum_o,
  output logic signed [ValW-1:0] gated_minimum_o,
  output logic signed [ValW-1:0] gated_maximum_o,
  output logic [CntW-1:0]        samples_o,
  output logic [TsW-1:0]         rollover_id_o,
  output logic                   last_o
);

  logic [IntervalW-1:0]   interval_q;

  logic                   itm_vld_q, itm_vld_d;
  logic [1:0]             itm_mode_q;
  logic [TsW-1:0]         itm_ts_q;
  logic signed [ValW-1:0] itm_raw_q;
  logic signed [ValW-1:0] itm_gat_q;

  logic [TsW-1:0]         requested_q, requested_d;
  logic [TsW-1:0]         served_q, served_d;
  logic                   open_q, open_d;
  logic                   snap_rdy_q, snap_rdy_d;
  logic [TsW-1:0]         win_start_q, win_start_d;
  logic [TsW-1:0]         win_end_q, win_end_d;
  logic signed [ValW-1:0] raw_lo_q, raw_lo_d;
  logic signed [ValW-1:0] raw_hi_q, raw_hi_d;
  logic signed [ValW-1:0] gat_lo_q, gat_lo_d;
  logic signed [ValW-1:0] gat_hi_q, gat_hi_d;
  logic [CntW-1:0]        total_q, total_d;

  rec_t                   rec_q [MaxRes];
  rec_t                   rec_d [MaxRes];
  rec_t                   new_rec [MaxRes];
  logic [1:0]             cnt_q, cnt_d;
  logic [1:0]             nres;

  logic                   in_fire;
  logic                   out_fire;
  logic                   load;

  logic                   req_due;
  logic                   int_due;
  logic                   close;
  logic                   open_eff;
  logic [TsW-1:0]         ts_diff;
  logic [TsW-1:0]         close_t;
  logic [TsW-1:0]         interval_ext;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign load        = itm_vld_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_fire));
  assign in_ready_o  = !itm_vld_q || load;
  assign in_fire     = in_valid_i && in_ready_o;

  assign interval_ext = {{(TsW-IntervalW){1'b0}}, interval_q};
  assign ts_diff      = itm_ts_q - win_start_q;
  assign req_due      = (requested_q != served_q);
  assign int_due      = open_q && (interval_q != '0) && (itm_ts_q >= win_start_q) &&
                        (ts_diff >= interval_ext);
  assign close        = req_due || int_due;
  assign close_t      = int_due ? (win_start_q + interval_ext) : itm_ts_q;
  assign open_eff     = open_q && !close;

  always_comb begin
    itm_vld_d = in_fire ? 1'b1 : (load ? 1'b0 : itm_vld_q);
  end

  always_comb begin
    requested_d = requested_q;
    served_d    = served_q;
    open_d      = open_q;
    snap_rdy_d  = snap_rdy_q;
    win_start_d = win_start_q;
    win_end_d   = win_end_q;
    raw_lo_d    = raw_lo_q;
    raw_hi_d    = raw_hi_q;
    gat_lo_d    = gat_lo_q;
    gat_hi_d    = gat_hi_q;
    total_d     = total_q;
    nres        = 2'd0;
    for (int i = 0; i < MaxRes; i++) begin
      new_rec[i] = '0;
    end

    if (load) begin
      case (itm_mode_q)
        MODE_REQUEST: begin
          requested_d             = requested_q + 64'd1;
          new_rec[0].kind         = KIND_ACK;
          new_rec[0].ready_res    = 1'b1;
          new_rec[0].end_ns       = itm_ts_q;
          new_rec[0].rollover_id  = requested_q + 64'd1;
          nres                    = 2'd1;
        end
        MODE_RESET: begin
          snap_rdy_d              = 1'b0;
          open_d                  = 1'b0;
          win_start_d             = '0;
          win_end_d               = '0;
          raw_lo_d                = '0;
          raw_hi_d                = '0;
          gat_lo_d                = '0;
          gat_hi_d                = '0;
          total_d                 = '0;
          served_d                = requested_q;
          new_rec[0].kind         = KIND_SNAPSHOT;
          new_rec[1].kind         = KIND_WINDOW;
          new_rec[1].rollover_id  = requested_q;
          nres                    = 2'd2;
        end
        MODE_SAMPLE: begin
          if (close) begin
            if (snap_rdy_q) begin
              new_rec[nres].kind      = KIND_SNAPSHOT;
              new_rec[nres].ready_res = 1'b1;
              nres                    = nres + 2'd1;
            end
            new_rec[nres].kind        = KIND_WINDOW;
            new_rec[nres].ready_res   = 1'b1;
            new_rec[nres].start_ns    = (total_q == '0) ? close_t : win_start_q;
            new_rec[nres].end_ns      = close_t;
            new_rec[nres].raw_min     = raw_lo_q;
            new_rec[nres].raw_max     = raw_hi_q;
            new_rec[nres].gat_min     = gat_lo_q;
            new_rec[nres].gat_max     = gat_hi_q;
            new_rec[nres].samples     = total_q;
            new_rec[nres].rollover_id = requested_q;
            nres                      = nres + 2'd1;
            served_d                  = requested_q;
          end
          snap_rdy_d = 1'b1;
          if (!open_eff) begin
            open_d      = 1'b1;
            win_start_d = itm_ts_q;
            win_end_d   = itm_ts_q;
            raw_lo_d    = itm_raw_q;
            raw_hi_d    = itm_raw_q;
            gat_lo_d    = itm_gat_q;
            gat_hi_d    = itm_gat_q;
            total_d     = 32'd1;
          end else begin
            win_end_d = itm_ts_q;
            raw_lo_d  = (itm_raw_q < raw_lo_q) ? itm_raw_q : raw_lo_q;
            raw_hi_d  = (raw_hi_q < itm_raw_q) ? itm_raw_q : raw_hi_q;
            gat_lo_d  = (itm_gat_q < gat_lo_q) ? itm_gat_q : gat_lo_q;
            gat_hi_d  = (gat_hi_q < itm_gat_q) ? itm_gat_q : gat_hi_q;
            total_d   = (total_q == '1) ? total_q : total_q + 32'd1;
          end
          new_rec[nres].kind      = KIND_SNAPSHOT;
          new_rec[nres].ready_res = 1'b1;
          new_rec[nres].start_ns  = win_start_d;
          new_rec[nres].end_ns    = win_end_d;
          new_rec[nres].raw_min   = raw_lo_d;
          new_rec[nres].raw_max   = raw_hi_d;
          new_rec[nres].gat_min   = gat_lo_d;
          new_rec[nres].gat_max   = gat_hi_d;
          new_rec[nres].samples   = total_d;
          nres                    = nres + 2'd1;
        end
        default: begin
          nres = 2'd0;
        end
      endcase
    end

    for (int i = 0; i < MaxRes; i++) begin
      new_rec[i].last = ((2'(i) + 2'd1) == nres);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxRes; i++) begin
      rec_d[i] = rec_q[i];
    end
    if (load) begin
      cnt_d = nres;
      for (int i = 0; i < MaxRes; i++) begin
        rec_d[i] = new_rec[i];
      end
    end else if (out_fire) begin
      cnt_d    = cnt_q - 2'd1;
      rec_d[0] = rec_q[1];
      rec_d[1] = rec_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= '0;
      itm_vld_q   <= 1'b0;
      cnt_q       <= 2'd0;
      requested_q <= '0;
      served_q    <= '0;
      open_q      <= 1'b0;
      snap_rdy_q  <= 1'b0;
      win_start_q <= '0;
      win_end_q   <= '0;
      raw_lo_q    <= '0;
      raw_hi_q    <= '0;
      gat_lo_q    <= '0;
      gat_hi_q    <= '0;
      total_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      itm_vld_q   <= itm_vld_d;
      cnt_q       <= cnt_d;
      requested_q <= requested_d;
      served_q    <= served_d;
      open_q      <= open_d;
      snap_rdy_q  <= snap_rdy_d;
      win_start_q <= win_start_d;
      win_end_q   <= win_end_d;
      raw_lo_q    <= raw_lo_d;
      raw_hi_q    <= raw_hi_d;
      gat_lo_q    <= gat_lo_d;
      gat_hi_q    <= gat_hi_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      itm_mode_q <= mode_i;
      itm_ts_q   <= timestamp_ns_i;
      itm_raw_q  <= raw_cross_i;
      itm_gat_q  <= gated_cross_i;
    end
    for (int i = 0; i < MaxRes; i++) begin
      rec_q[i] <= rec_d[i];
    end
  end

  assign kind_o          = rec_q[0].kind;
  assign ready_res_o     = rec_q[0].ready_res;
  assign start_ns_o      = rec_q[0].start_ns;
  assign end_ns_o        = rec_q[0].end_ns;
  assign raw_minimum_o   = rec_q[0].raw_min;
  assign raw_maximum_o   = rec_q[0].raw_max;
  assign gated_minimum_o = rec_q[0].gat_min;
  assign gated_maximum_o = rec_q[0].gat_max;
  assign samples_o       = rec_q[0].samples;
  assign rollover_id_o   = rec_q[0].rollover_id;
  assign last_o          = rec_q[0].last;

`ifndef ASSERT_OFF
  a_sample_serves_requests: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (itm_mode_q == MODE_SAMPLE)) |=> (served_q == requested_q))
    else $error("pending rollover request survived a sample");

  a_sample_opens_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (itm_mode_q == MODE_SAMPLE)) |=> (open_q && (total_q != '0) && snap_rdy_q))
    else $error("window not open after a sample was folded in");

  a_last_on_final_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rec_q[0].last == (cnt_q == 2'd1)))
    else $error("last flag does not mark the final queued word");

  a_min_not_above_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> ((raw_lo_q <= raw_hi_q) && (gat_lo_q <= gat_hi_q)))
    else $error("window minimum above maximum");

  a_no_load_over_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 2'd1) |-> !load)
    else $error("results loaded while earlier words still queued");
`endif

endmodule
